// ===== src/jsu_pkg.sv =====
// Shared types and result codes for the JSON string unescaper.
`default_nettype none
package jsu_pkg;

  localparam int unsigned MaxRes = 4;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [3:0] ERR_NONE         = 4'd0;
  localparam logic [3:0] ERR_NO_QUOTE     = 4'd1;
  localparam logic [3:0] ERR_END_AFTER_BS = 4'd2;
  localparam logic [3:0] ERR_BAD_ESCAPE   = 4'd3;
  localparam logic [3:0] ERR_SHORT_HEX    = 4'd4;
  localparam logic [3:0] ERR_BAD_HEX      = 4'd5;
  localparam logic [3:0] ERR_MISSING_LOW  = 4'd6;
  localparam logic [3:0] ERR_BAD_LOW      = 4'd7;
  localparam logic [3:0] ERR_LONE_LOW     = 4'd8;
  localparam logic [3:0] ERR_CONTROL      = 4'd9;
  localparam logic [3:0] ERR_UNTERMINATED = 4'd10;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } jsu_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [3:0] error_code;
    logic       last_of_run;
  } jsu_out_t;

endpackage
`default_nettype wire

// ===== src/json_string_unescape.sv =====
// Top level of the JSON string unescaper: input register, decoder, result buffer.
// Decodes one quoted JSON string literal, one text byte per transfer, into UTF-8 bytes
// followed by a completion result, or an error result (after which the next opening
// quote is awaited). Each input byte is registered, decoded combinationally and its
// results (none to four) are loaded into a four-entry result buffer that drains one
// result per cycle when out_stall is low; last_of_run marks the final result of
// each byte. The first result of a byte appears after the input register and the
// result buffer. With out_stall low, a byte giving at most one result is taken every
// cycle; a byte giving more holds the single output port and the input waits.
`default_nettype none
module json_string_unescape import jsu_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire jsu_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output jsu_out_t      out_data
);

  logic                  in_vld_r;
  jsu_in_t               in_r;
  jsu_out_t              buf_r [MaxRes];
  logic [2:0]            cnt_r;
  logic [1:0]            idx_r;
  logic                  out_xfer;
  logic                  load;
  jsu_out_t [MaxRes-1:0] res;
  logic [2:0]            res_cnt;

  assign out_valid = (cnt_r != 3'd0);
  assign out_xfer  = out_valid && !out_stall;
  // Move the held byte into the buffer once the previous burst is gone.
  assign load      = in_vld_r && ((cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_xfer));
  assign in_stall  = in_vld_r && !load;

  jsu_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (in_r),
    .load    (load),
    .res     (res),
    .res_cnt (res_cnt)
  );

  always_comb begin
    out_data             = buf_r[idx_r];
    out_data.last_of_run = (cnt_r == 3'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (load) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
      idx_r <= 2'd0;
    end else if (load) begin
      cnt_r <= res_cnt;
      idx_r <= 2'd0;
    end else if (out_xfer) begin
      cnt_r <= cnt_r - 3'd1;
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MaxRes; i++) begin
        buf_r[i] <= res[i];
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4)
    else $error("result count out of range");

  a_code_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != KIND_ERROR |-> out_data.error_code == ERR_NONE)
    else $error("error code on a non-error result");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != KIND_DATA |-> out_data.out_byte == 8'd0 &&
      out_data.last_of_run)
    else $error("completion or error result not the last of its run");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load && res_cnt != 3'd0 |=> out_valid && idx_r == 2'd0)
    else $error("loaded burst not presented");

endmodule
`default_nettype wire

// ===== src/jsu_decode.sv =====
// Escape decoder: parse state plus the results that one text byte produces.
`default_nettype none
module jsu_decode import jsu_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire jsu_in_t              item,
  input  wire logic                 load,
  output jsu_out_t [MaxRes-1:0]     res,
  output logic     [2:0]            res_cnt
);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_BODY   = 3'd1,
    PH_ESC    = 3'd2,
    PH_HEX1   = 3'd3,
    PH_NEEDBS = 3'd4,
    PH_NEEDU  = 3'd5,
    PH_HEX2   = 3'd6
  } phase_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_SPACE = 8'h20;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  hex_r, hex_nxt;
  logic [15:0] first_r, first_nxt;
  logic [15:0] second_r, second_nxt;

  logic [7:0]  c;
  logic        eot;
  logic        hex_ok;
  logic [3:0]  hex_d;
  logic [15:0] first_new, second_new;
  logic [20:0] cp;
  jsu_out_t [MaxRes-1:0] enc;
  logic [2:0]  enc_cnt;

  assign c   = item.data_byte;
  assign eot = item.end_of_text;

  always_comb begin
    hex_ok = 1'b1;
    hex_d  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_d = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      hex_d = c[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign first_new  = {first_r[11:0], hex_d};
  assign second_new = {second_r[11:0], hex_d};

  // Pair combine concatenates the ten payload bits of each unit and adds 0x10000.
  assign cp = (phase_r == PH_HEX2) ?
              ({1'b0, first_r[9:0], second_new[9:0]} + 21'h10000) :
              {5'd0, first_new};

  always_comb begin
    enc = '0;
    if (cp <= 21'h7F) begin
      enc_cnt = 3'd1;
      enc[0].out_byte = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      enc_cnt = 3'd2;
      enc[0].out_byte = {3'b110, cp[10:6]};
      enc[1].out_byte = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      enc_cnt = 3'd3;
      enc[0].out_byte = {4'b1110, cp[15:12]};
      enc[1].out_byte = {2'b10, cp[11:6]};
      enc[2].out_byte = {2'b10, cp[5:0]};
    end else begin
      enc_cnt = 3'd4;
      enc[0].out_byte = {5'b11110, cp[20:18]};
      enc[1].out_byte = {2'b10, cp[17:12]};
      enc[2].out_byte = {2'b10, cp[11:6]};
      enc[3].out_byte = {2'b10, cp[5:0]};
    end
  end

  always_comb begin
    logic       fail;
    logic [3:0] code;
    fail       = 1'b0;
    code       = ERR_NONE;
    phase_nxt  = phase_r;
    hex_nxt    = hex_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    res        = '0;
    res_cnt    = 3'd0;
    unique case (phase_r)
      PH_BODY: begin
        if (eot) begin
          fail = 1'b1; code = ERR_UNTERMINATED;
        end else if (c == CH_QUOTE) begin
          res[0].kind = KIND_DONE;
          res_cnt     = 3'd1;
          phase_nxt   = PH_IDLE;
          hex_nxt     = 2'd0;
          first_nxt   = '0;
          second_nxt  = '0;
        end else if (c == CH_BSL) begin
          phase_nxt = PH_ESC;
        end else if (c < CH_SPACE) begin
          fail = 1'b1; code = ERR_CONTROL;
        end else begin
          res[0].out_byte = c;
          res_cnt         = 3'd1;
        end
      end
      PH_ESC: begin
        if (eot) begin
          fail = 1'b1; code = ERR_END_AFTER_BS;
        end else begin
          phase_nxt = PH_BODY;
          res_cnt   = 3'd1;
          case (c)
            CH_QUOTE, CH_BSL, CH_SLASH: res[0].out_byte = c;
            CH_B: res[0].out_byte = 8'h08;
            CH_F: res[0].out_byte = 8'h0C;
            CH_N: res[0].out_byte = 8'h0A;
            CH_R: res[0].out_byte = 8'h0D;
            CH_T: res[0].out_byte = 8'h09;
            CH_U: begin
              res_cnt   = 3'd0;
              phase_nxt = PH_HEX1;
              hex_nxt   = 2'd0;
              first_nxt = '0;
            end
            default: begin
              res_cnt = 3'd0;
              fail = 1'b1; code = ERR_BAD_ESCAPE;
            end
          endcase
        end
      end
      PH_HEX1: begin
        if (eot) begin
          fail = 1'b1; code = ERR_SHORT_HEX;
        end else if (!hex_ok) begin
          fail = 1'b1; code = ERR_BAD_HEX;
        end else begin
          first_nxt = first_new;
          hex_nxt   = hex_r + 2'd1;
          if (hex_r == 2'd3) begin
            if (first_new[15:10] == 6'b110110) begin
              phase_nxt = PH_NEEDBS;
            end else if (first_new[15:10] == 6'b110111) begin
              fail = 1'b1; code = ERR_LONE_LOW;
            end else begin
              res       = enc;
              res_cnt   = enc_cnt;
              phase_nxt = PH_BODY;
            end
          end
        end
      end
      PH_NEEDBS: begin
        if (eot || c != CH_BSL) begin
          fail = 1'b1; code = ERR_MISSING_LOW;
        end else begin
          phase_nxt = PH_NEEDU;
        end
      end
      PH_NEEDU: begin
        if (eot || c != CH_U) begin
          fail = 1'b1; code = ERR_MISSING_LOW;
        end else begin
          phase_nxt  = PH_HEX2;
          hex_nxt    = 2'd0;
          second_nxt = '0;
        end
      end
      PH_HEX2: begin
        if (eot) begin
          fail = 1'b1; code = ERR_SHORT_HEX;
        end else if (!hex_ok) begin
          fail = 1'b1; code = ERR_BAD_HEX;
        end else begin
          second_nxt = second_new;
          hex_nxt    = hex_r + 2'd1;
          if (hex_r == 2'd3) begin
            if (second_new[15:10] != 6'b110111) begin
              fail = 1'b1; code = ERR_BAD_LOW;
            end else begin
              res       = enc;
              res_cnt   = enc_cnt;
              phase_nxt = PH_BODY;
            end
          end
        end
      end
      default: begin
        if (eot || c != CH_QUOTE) begin
          fail = 1'b1; code = ERR_NO_QUOTE;
        end else begin
          phase_nxt  = PH_BODY;
          hex_nxt    = 2'd0;
          first_nxt  = '0;
          second_nxt = '0;
        end
      end
    endcase
    if (fail) begin
      res              = '0;
      res[0].kind       = KIND_ERROR;
      res[0].error_code = code;
      res_cnt          = 3'd1;
      phase_nxt        = PH_IDLE;
      hex_nxt          = 2'd0;
      first_nxt        = '0;
      second_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      hex_r    <= 2'd0;
      first_r  <= '0;
      second_r <= '0;
    end else if (load) begin
      phase_r  <= phase_nxt;
      hex_r    <= hex_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/json_string_unescape_tb.sv =====
// Self-checking bench for the JSON string unescaper: directed and random text, predicted UTF-8.
`timescale 1ns / 100ps
module json_string_unescape_tb;
  import jsu_pkg::*;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam int unsigned RandomItems = 260;

  typedef enum logic [2:0] {
    ST_IDLE, ST_BODY, ST_ESC, ST_HEX1, ST_NEEDBS, ST_NEEDU, ST_HEX2
  } scan_state_t;

  typedef struct {
    jsu_in_t item;
    bit      settle;
  } pending_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  jsu_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  jsu_out_t out_data;

  pending_t    text_q[$];
  jsu_out_t    decoded_q[$];
  pending_t    next_item;
  jsu_out_t    oldest;
  bit          settle_next = 1'b0;
  int unsigned bytes_taken = 0;
  int unsigned total_items = 0;
  int unsigned failures = 0;
  logic        calm;

  // Predictor state
  scan_state_t scan_st = ST_IDLE;
  logic [2:0]  digit_cnt = '0;
  logic [15:0] high_unit = '0;
  logic [15:0] low_unit = '0;

  logic [7:0] esc_set [8] = '{8'h22, 8'h5C, 8'h2F, "b", "f", "n", "r", "t"};

  json_string_unescape u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // No random idling on either side during this stretch of transfers
  assign calm = (bytes_taken >= 120) && (bytes_taken < 200);

  function automatic int hex_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  task automatic push_result(logic [7:0] b, logic [1:0] k, logic [3:0] code);
    jsu_out_t r;
    r.out_byte    = b;
    r.kind        = k;
    r.error_code  = code;
    r.last_of_run = 1'b0;
    decoded_q = {decoded_q, r};
  endtask

  task automatic back_to_idle();
    scan_st   = ST_IDLE;
    digit_cnt = '0;
    high_unit = '0;
    low_unit  = '0;
  endtask

  task automatic abort_string(logic [3:0] code);
    push_result(8'h00, KIND_ERROR, code);
    back_to_idle();
  endtask

  task automatic put_code_point(logic [20:0] cp);
    if (cp <= 21'h7F) begin
      push_result({1'b0, cp[6:0]}, KIND_DATA, ERR_NONE);
    end else if (cp <= 21'h7FF) begin
      push_result({3'b110, cp[10:6]}, KIND_DATA, ERR_NONE);
      push_result({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
    end else if (cp <= 21'hFFFF) begin
      push_result({4'b1110, cp[15:12]}, KIND_DATA, ERR_NONE);
      push_result({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
      push_result({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
    end else begin
      push_result({5'b11110, cp[20:18]}, KIND_DATA, ERR_NONE);
      push_result({2'b10, cp[17:12]}, KIND_DATA, ERR_NONE);
      push_result({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
      push_result({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
    end
  endtask

  // Work out the results of one accepted text byte and append them to decoded_q
  task automatic unescape_step(jsu_in_t it);
    int          base;
    int          d;
    logic [7:0]  c;
    jsu_out_t    tail;
    base = decoded_q.size();
    c = it.data_byte;
    d = hex_value(c);
    case (scan_st)
      ST_BODY: begin
        if (it.end_of_text) abort_string(ERR_UNTERMINATED);
        else if (c == CH_QUOTE) begin
          push_result(8'h00, KIND_DONE, ERR_NONE);
          back_to_idle();
        end else if (c == CH_BSLASH) scan_st = ST_ESC;
        else if (c < 8'h20) abort_string(ERR_CONTROL);
        else push_result(c, KIND_DATA, ERR_NONE);
      end
      ST_ESC: begin
        if (it.end_of_text) abort_string(ERR_END_AFTER_BS);
        else begin
          scan_st = ST_BODY;
          case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH: push_result(c, KIND_DATA, ERR_NONE);
            "b": push_result(8'h08, KIND_DATA, ERR_NONE);
            "f": push_result(8'h0C, KIND_DATA, ERR_NONE);
            "n": push_result(8'h0A, KIND_DATA, ERR_NONE);
            "r": push_result(8'h0D, KIND_DATA, ERR_NONE);
            "t": push_result(8'h09, KIND_DATA, ERR_NONE);
            CH_U: begin
              scan_st   = ST_HEX1;
              digit_cnt = '0;
              high_unit = '0;
            end
            default: abort_string(ERR_BAD_ESCAPE);
          endcase
        end
      end
      ST_HEX1, ST_HEX2: begin
        if (it.end_of_text) abort_string(ERR_SHORT_HEX);
        else if (d < 0) abort_string(ERR_BAD_HEX);
        else begin
          if (scan_st == ST_HEX1) high_unit = {high_unit[11:0], 4'(d)};
          else low_unit = {low_unit[11:0], 4'(d)};
          digit_cnt = digit_cnt + 3'd1;
          if (digit_cnt == 3'd4) begin
            digit_cnt = '0;
            if (scan_st == ST_HEX1) begin
              if (high_unit >= 16'hD800 && high_unit <= 16'hDBFF) scan_st = ST_NEEDBS;
              else if (high_unit >= 16'hDC00 && high_unit <= 16'hDFFF)
                abort_string(ERR_LONE_LOW);
              else begin
                put_code_point({5'd0, high_unit});
                scan_st = ST_BODY;
              end
            end else if (low_unit < 16'hDC00 || low_unit > 16'hDFFF) begin
              abort_string(ERR_BAD_LOW);
            end else begin
              put_code_point(21'h10000 + {1'b0, high_unit[9:0], low_unit[9:0]});
              scan_st = ST_BODY;
            end
          end
        end
      end
      ST_NEEDBS: begin
        if (it.end_of_text || c != CH_BSLASH) abort_string(ERR_MISSING_LOW);
        else scan_st = ST_NEEDU;
      end
      ST_NEEDU: begin
        if (it.end_of_text || c != CH_U) abort_string(ERR_MISSING_LOW);
        else begin
          scan_st   = ST_HEX2;
          digit_cnt = '0;
          low_unit  = '0;
        end
      end
      default: begin
        if (it.end_of_text || c != CH_QUOTE) abort_string(ERR_NO_QUOTE);
        else begin
          back_to_idle();
          scan_st = ST_BODY;
        end
      end
    endcase
    // Mark the final result of this byte
    if (decoded_q.size() > base) begin
      tail = decoded_q[decoded_q.size() - 1];
      tail.last_of_run = 1'b1;
      decoded_q[decoded_q.size() - 1] = tail;
    end
  endtask

  // Stimulus builders
  task automatic queue_byte(logic [7:0] b);
    pending_t p;
    p.item.data_byte   = b;
    p.item.end_of_text = 1'b0;
    p.settle = settle_next;
    settle_next = 1'b0;
    text_q = {text_q, p};
  endtask

  task automatic queue_end();
    pending_t p;
    p.item.data_byte   = 8'($urandom_range(0, 255));
    p.item.end_of_text = 1'b1;
    p.settle = settle_next;
    settle_next = 1'b0;
    text_q = {text_q, p};
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'("0") + 8'(n);
    if ($urandom_range(0, 1) == 0) return 8'("a") + 8'(n - 4'd10);
    return 8'("A") + 8'(n - 4'd10);
  endfunction

  task automatic queue_digits(logic [15:0] v, int count);
    for (int i = 0; i < count; i++) queue_byte(hex_char(v[15 - 4*i -: 4]));
  endtask

  task automatic queue_u_escape(logic [15:0] v);
    queue_byte(CH_BSLASH);
    queue_byte(CH_U);
    queue_digits(v, 4);
  endtask

  // Pick within a range, leaning on its ends
  function automatic logic [15:0] span(logic [15:0] a, logic [15:0] b);
    case ($urandom_range(0, 7))
      0: return a;
      1: return b;
      default: return 16'($urandom_range(a, b));
    endcase
  endfunction

  function automatic logic [15:0] random_bmp();
    case ($urandom_range(0, 3))
      0: return span(16'h0000, 16'h007F);
      1: return span(16'h0080, 16'h07FF);
      2: return span(16'h0800, 16'hD7FF);
      default: return span(16'hE000, 16'hFFFF);
    endcase
  endfunction

  function automatic logic [7:0] random_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(8'h20, 8'hFF)); while (b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  function automatic logic [7:0] random_non_hex();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (hex_value(b) >= 0);
    return b;
  endfunction

  function automatic bit is_escape(logic [7:0] b);
    foreach (esc_set[i]) if (esc_set[i] == b) return 1'b1;
    return b == CH_U;
  endfunction

  // Faults that end the current string with an error
  task automatic queue_fault();
    logic [7:0]  b;
    logic [15:0] hi;
    hi = span(16'hD800, 16'hDBFF);
    case ($urandom_range(0, 10))
      0: queue_byte(8'($urandom_range(0, 8'h1F)));
      1: begin
        do b = 8'($urandom_range(0, 255)); while (is_escape(b));
        queue_byte(CH_BSLASH);
        queue_byte(b);
      end
      2: begin
        queue_byte(CH_BSLASH);
        queue_end();
      end
      3: begin
        queue_byte(CH_BSLASH);
        queue_byte(CH_U);
        queue_digits(16'($urandom), $urandom_range(0, 3));
        queue_end();
      end
      4: begin
        queue_byte(CH_BSLASH);
        queue_byte(CH_U);
        queue_digits(16'($urandom), $urandom_range(0, 3));
        queue_byte(random_non_hex());
      end
      5: queue_u_escape(span(16'hDC00, 16'hDFFF));
      6: begin
        queue_u_escape(hi);
        if ($urandom_range(0, 3) == 0) queue_end();
        else begin
          do b = 8'($urandom_range(0, 255)); while (b == CH_BSLASH);
          queue_byte(b);
        end
      end
      7: begin
        queue_u_escape(hi);
        queue_byte(CH_BSLASH);
        if ($urandom_range(0, 3) == 0) queue_end();
        else begin
          do b = 8'($urandom_range(0, 255)); while (b == CH_U);
          queue_byte(b);
        end
      end
      8: begin
        queue_u_escape(hi);
        if ($urandom_range(0, 1) == 0) queue_u_escape(span(16'h0000, 16'hDBFF));
        else queue_u_escape(span(16'hE000, 16'hFFFF));
      end
      9: begin
        queue_u_escape(hi);
        queue_byte(CH_BSLASH);
        queue_byte(CH_U);
        queue_digits(16'($urandom), $urandom_range(0, 3));
        if ($urandom_range(0, 1) == 0) queue_end();
        else queue_byte(random_non_hex());
      end
      default: queue_end();
    endcase
  endtask

  task automatic queue_string();
    int  n_elems;
    int  pick;
    bit  broken;
    logic [7:0] b;
    n_elems = $urandom_range(0, 7);
    broken = 1'b0;
    if ($urandom_range(0, 9) == 0) settle_next = 1'b1;
    // Occasional junk before the opening quote
    if ($urandom_range(0, 11) == 0) begin
      if ($urandom_range(0, 1) == 0) queue_end();
      else begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
        queue_byte(b);
      end
    end
    queue_byte(CH_QUOTE);
    for (int e = 0; e < n_elems && !broken; e++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) queue_byte(random_plain());
      else if (pick < 55) begin
        queue_byte(CH_BSLASH);
        queue_byte(esc_set[$urandom_range(0, 7)]);
      end else if (pick < 72) queue_u_escape(random_bmp());
      else if (pick < 88) begin
        queue_u_escape(span(16'hD800, 16'hDBFF));
        queue_u_escape(span(16'hDC00, 16'hDFFF));
      end else begin
        broken = 1'b1;
        queue_fault();
      end
    end
    if (!broken) begin
      if ($urandom_range(0, 9) == 0) queue_end();
      else queue_byte(CH_QUOTE);
    end
  endtask

  // Driver: predict on each transfer, then present the next pending byte
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      back_to_idle();
    end else begin
      if (in_valid && !in_stall) begin
        unescape_step(in_data);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (text_q.size() != 0 && !(text_q[0].settle && decoded_q.size() != 0)
            && !(!calm && $urandom_range(0, 99) < 9)) begin
          next_item = text_q.pop_front();
          in_data  <= next_item.item;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected result: out_byte %h kind %0d error_code %0d last_of_run %0b",
                 out_data.out_byte, out_data.kind, out_data.error_code, out_data.last_of_run);
          failures++;
        end else begin
          oldest = decoded_q.pop_front();
          if (out_data.out_byte !== oldest.out_byte) begin
            $error("out_byte: expected %h, got %h", oldest.out_byte, out_data.out_byte);
            failures++;
          end
          if (out_data.kind !== oldest.kind) begin
            $error("kind: expected %0d, got %0d", oldest.kind, out_data.kind);
            failures++;
          end
          if (out_data.error_code !== oldest.error_code) begin
            $error("error_code: expected %0d, got %0d", oldest.error_code, out_data.error_code);
            failures++;
          end
          if (out_data.last_of_run !== oldest.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", oldest.last_of_run,
                   out_data.last_of_run);
            failures++;
          end
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 9);
    end
  end

  initial begin
    rst_n = 1'b0;
    // Directed: junk and end of text before a quote, byte extremes, a surrogate pair,
    // a control byte, end of text right after a backslash
    queue_byte(8'h00);
    queue_end();
    queue_byte(CH_QUOTE);
    queue_byte(8'hFF);
    queue_byte(8'h20);
    queue_u_escape(16'hD83D);
    queue_u_escape(16'hDE00);
    queue_byte(CH_QUOTE);
    queue_byte(CH_QUOTE);
    queue_byte(8'h1F);
    queue_byte(CH_QUOTE);
    queue_byte(CH_BSLASH);
    queue_end();
    // Hold the first random string until the directed results have drained
    settle_next = 1'b1;
    total_items = text_q.size() + RandomItems;
    while (text_q.size() < total_items) queue_string();
    total_items = text_q.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_taken < total_items) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (failures == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
